// ----- hdl/sha1_stream_hash_top_macros.svh -----
// assertion macros for the sha1 stream hash checker
// expects clk and rst_n to be visible where the macros are used
`ifndef SHA1_STREAM_HASH_TOP_MACROS_SVH
`define SHA1_STREAM_HASH_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SHA1SH_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SHA1SH_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/sha1sh_pkg.sv -----
// shared types and constants of the sha1 stream hasher
// no dependencies
`default_nettype none

package sha1sh_pkg;

    localparam int QUEUE_DEPTH = 4;

    // input op codes
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

`default_nettype wire

// ----- hdl/sha1sh_if.sv -----
// valid/ready channel interfaces of the sha1 stream hasher
// no dependencies
`default_nettype none

interface sha1sh_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
    modport mon    (input valid, input op, input data_byte, input ready);
endinterface

interface sha1sh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;

    modport source (output valid, output digest_word0, output digest_word1,
                    output digest_word2, output digest_word3, output digest_word4,
                    input ready);
    modport sink   (input valid, input digest_word0, input digest_word1,
                    input digest_word2, input digest_word3, input digest_word4,
                    output ready);
    modport mon    (input valid, input digest_word0, input digest_word1,
                    input digest_word2, input digest_word3, input digest_word4,
                    input ready);
endinterface

`default_nettype wire

// ----- hdl/sha1sh_front.sv -----
// front end: accepts input words, classifies the op and queues commands
// depends on sha1sh_pkg and sha1sh_if
`default_nettype none

module sha1sh_front #(
    parameter int DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    sha1sh_in_if.sink          in_chan,
    output sha1sh_pkg::cmd_t   cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha1sh_pkg::cmd_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    sha1sh_pkg::cmd_t in_cmd;
    logic             keep;
    logic             push;
    logic             pop;

    // unused op code is accepted and dropped
    always_comb
    begin
        in_cmd.data = in_chan.data_byte;
        keep        = 1'b1;
        unique case (in_chan.op)
            sha1sh_pkg::OP_BEGIN:  in_cmd.kind = sha1sh_pkg::CMD_BEGIN;
            sha1sh_pkg::OP_BYTE:   in_cmd.kind = sha1sh_pkg::CMD_BYTE;
            sha1sh_pkg::OP_FINISH: in_cmd.kind = sha1sh_pkg::CMD_FINISH;
            default:
            begin
                in_cmd.kind = sha1sh_pkg::CMD_BEGIN;
                keep        = 1'b0;
            end
        endcase
    end

    assign in_chan.ready = (count_reg != CNT_W'(DEPTH));
    assign push          = in_chan.valid && in_chan.ready && keep;
    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_valid && cmd_ready;
    assign cmd           = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sha1sh_core.sv -----
// back end: block buffer, padding sequencer and one-round-per-cycle compression
// depends on sha1sh_pkg and sha1sh_if
`default_nettype none

module sha1sh_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sha1sh_pkg::cmd_t  cmd,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    sha1sh_out_if.source           out_chan
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [3:0] LEN_BYTES  = 4'd8;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LEN_FILL   = 6'd56;

    state_t      state_reg, state_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] count_reg, count_next;
    logic [5:0]  fill_reg, fill_next;
    logic [6:0]  round_reg, round_next;
    logic        padding_reg, padding_next;
    logic        pad_first_reg, pad_first_next;
    logic [3:0]  len_cnt_reg, len_cnt_next;
    logic [63:0] len_reg, len_next;

    // block buffer doubles as the message schedule window, word 0 is the current w
    logic [31:0] buf_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic        push_en;
    logic [7:0]  push_byte;
    logic        load_work;
    logic        round_en;
    logic [31:0] f_val, k_val, t_val, w_new;

    assign cmd_ready             = (state_reg == ST_IDLE);
    assign out_chan.valid        = (state_reg == ST_OUT);
    assign out_chan.digest_word0 = chain_reg[0];
    assign out_chan.digest_word1 = chain_reg[1];
    assign out_chan.digest_word2 = chain_reg[2];
    assign out_chan.digest_word3 = chain_reg[3];
    assign out_chan.digest_word4 = chain_reg[4];

    always_comb
    begin
        priority if (round_reg < 7'd20)
        begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = sha1sh_pkg::K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k_val = sha1sh_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + buf_reg[0];
    end

    // w[t+16] from the window w[t..t+15]
    always_comb
    begin
        logic [31:0] x;
        x     = buf_reg[13] ^ buf_reg[8] ^ buf_reg[2] ^ buf_reg[0];
        w_new = {x[30:0], x[31]};
    end

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        padding_next   = padding_reg;
        pad_first_next = pad_first_reg;
        len_cnt_next   = len_cnt_reg;
        len_next       = len_reg;
        push_en        = 1'b0;
        push_byte      = 8'h00;
        load_work      = 1'b0;
        round_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        sha1sh_pkg::CMD_BEGIN:
                        begin
                            chain_next[0] = sha1sh_pkg::IV0;
                            chain_next[1] = sha1sh_pkg::IV1;
                            chain_next[2] = sha1sh_pkg::IV2;
                            chain_next[3] = sha1sh_pkg::IV3;
                            chain_next[4] = sha1sh_pkg::IV4;
                            count_next    = '0;
                            fill_next     = '0;
                        end
                        sha1sh_pkg::CMD_BYTE:
                        begin
                            count_next = count_reg + 32'd1;
                            push_en    = 1'b1;
                            push_byte  = cmd.data;
                        end
                        sha1sh_pkg::CMD_FINISH:
                        begin
                            padding_next   = 1'b1;
                            pad_first_next = 1'b1;
                            len_cnt_next   = '0;
                            // bit length, only the low 35 bits can be nonzero
                            len_next       = {29'd0, count_reg, 3'd0};
                            state_next     = ST_PAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                priority if (pad_first_reg)
                begin
                    push_byte      = sha1sh_pkg::PAD_BYTE;
                    pad_first_next = 1'b0;
                end
                else if (len_cnt_reg == '0 && fill_reg != LEN_FILL)
                begin
                    push_byte = 8'h00;
                end
                else
                begin
                    push_byte    = len_reg[63:56];
                    len_next     = {len_reg[55:0], 8'h00};
                    len_cnt_next = len_cnt_reg + 4'd1;
                end
            end
            ST_ROUND:
            begin
                round_en   = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                priority if (padding_reg && len_cnt_reg == LEN_BYTES)
                begin
                    padding_next = 1'b0;
                    state_next   = ST_OUT;
                end
                else if (padding_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_chan.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a full block starts the compression
        if (push_en)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_FILL)
            begin
                state_next = ST_ROUND;
                round_next = '0;
                load_work  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= sha1sh_pkg::IV0;
            chain_reg[1]  <= sha1sh_pkg::IV1;
            chain_reg[2]  <= sha1sh_pkg::IV2;
            chain_reg[3]  <= sha1sh_pkg::IV3;
            chain_reg[4]  <= sha1sh_pkg::IV4;
            count_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            padding_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            len_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            padding_reg   <= padding_next;
            pad_first_reg <= pad_first_next;
            len_cnt_reg   <= len_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (push_en)
        begin
            // whole block shifts left by one byte, new byte lands at the end
            for (int i = 0; i < 15; i++)
            begin
                buf_reg[i] <= {buf_reg[i][23:0], buf_reg[i+1][31:24]};
            end
            buf_reg[15] <= {buf_reg[15][23:0], push_byte};
        end
        else if (round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[15] <= w_new;
        end

        if (load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sha1_stream_hash_top.sv -----
// top level of the streaming sha1 hasher: command queue front end and hash core
// depends on sha1sh_pkg, sha1sh_if, sha1sh_front and sha1sh_core
`default_nettype none

//  channel    dir   payload                          handshake
//  in_chan    in    op[1:0], data_byte[7:0]          valid/ready
//  out_chan   out   digest_word0..digest_word4[31:0] valid/ready
//
//  a queue of QUEUE_DEPTH words sits between front and core; in_chan.ready drops only when full
//  core: takes a begin or data word while idle; a block-filling word runs 80 rounds, then the add
//  finish: pushes the pad and length bytes, compresses each full block, then the digest waits
//  the digest is held in the chaining register until out_chan takes it; the queue keeps filling
//  reset loads the standard initial chaining words; no clearing pass, the block buffer is not reset

module sha1_stream_hash_top #(
    parameter int QUEUE_DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sha1sh_in_if.sink     in_chan,
    sha1sh_out_if.source  out_chan
);

    sha1sh_pkg::cmd_t cmd;
    logic             cmd_valid;
    logic             cmd_ready;

    sha1sh_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    sha1sh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .out_chan  (out_chan)
    );

endmodule

`default_nettype wire

// ----- hdl/sha1sh_checker.sv -----
// port-level checks of the sha1 stream hasher, bound to the top level
// depends on sha1_stream_hash_top_macros.svh
`default_nettype none

`include "sha1_stream_hash_top_macros.svh"

module sha1sh_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_ready,
    input  wire logic        digest_valid,
    input  wire logic        digest_ready,
    input  wire logic [31:0] digest_word0,
    input  wire logic [31:0] digest_word1,
    input  wire logic [31:0] digest_word2,
    input  wire logic [31:0] digest_word3,
    input  wire logic [31:0] digest_word4
);

    logic [159:0] digest;
    logic         out_stall;
    logic         out_take;

    assign digest    = {digest_word4, digest_word3, digest_word2, digest_word1, digest_word0};
    assign out_stall = digest_valid && !digest_ready;
    assign out_take  = digest_valid && digest_ready;

    // a digest waiting for ready keeps valid up
    `SHA1SH_ASSERT_NEXT(a_out_hold, out_stall, digest_valid, "digest dropped while stalled")

    // a stalled digest keeps its value
    `SHA1SH_ASSERT_NEXT(a_out_stable, out_stall, $stable(digest), "digest changed while stalled")

    // two digests can never be delivered in adjacent cycles
    `SHA1SH_ASSERT_NEXT(a_out_gap, out_take, !digest_valid, "digest right after a digest")

    // queue is empty when reset is released
    `SHA1SH_ASSERT_NOW(a_ready_after_reset, $rose(rst_n), item_ready, "input not ready after reset")

endmodule

bind sha1_stream_hash_top sha1sh_checker u_sha1sh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (in_chan.ready),
    .digest_valid (out_chan.valid),
    .digest_ready (out_chan.ready),
    .digest_word0 (out_chan.digest_word0),
    .digest_word1 (out_chan.digest_word1),
    .digest_word2 (out_chan.digest_word2),
    .digest_word3 (out_chan.digest_word3),
    .digest_word4 (out_chan.digest_word4)
);

`default_nettype wire
